// ===== src/rope_pkg.sv =====
// ----------------------------------------------------------------------------
// rope_pkg: shared types, constants and float helpers
// Holds the default parameters, stage latencies, destination codes and the
// fp32 normalize and round functions used by the multiply and add pipelines.
// ----------------------------------------------------------------------------
package rope_pkg;

  localparam int DEF_HEAD_DIM        = 256;
  localparam int DEF_NUM_QUERY_HEADS = 8;

  localparam int MUL_LAT = 3;
  localparam int ADD_LAT = 4;

  localparam int PREFIX_W = 20;
  localparam int INDEX_W  = 29;

  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
  localparam logic [15:0] BF16_QNAN = 16'h7FC0;

  typedef enum logic [1:0] {
    KIND_QUERY = 2'd0,
    KIND_KEY   = 2'd1,
    KIND_VALUE = 2'd2
  } kind_t;

  // An exact value M * 2^E awaiting rounding, or a special value.
  typedef struct packed {
    logic               sign;
    logic               is_nan;
    logic               is_inf;
    logic               is_zero;
    logic signed [11:0] bexp;
    logic [31:0]        mant;
  } fnorm_t;

  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        n = 6'(31 - i);
      end
    end
    return n;
  endfunction

  // Shifts the leading one to bit 31 and turns E into a biased exponent.
  function automatic fnorm_t norm32(input fnorm_t r);
    fnorm_t     n;
    logic [5:0] lz;
    lz       = lzc32(r.mant);
    n        = r;
    n.mant   = r.mant << lz;
    n.bexp   = r.bexp + 12'sd158 - $signed({6'b0, lz});
    n.is_zero = r.is_zero | (r.mant == 32'd0);
    return n;
  endfunction

  // Rounds a normalized value to fp32 with ties to even, subnormals kept.
  function automatic logic [31:0] round32(input fnorm_t n);
    logic [31:0]        res;
    logic [7:0]         field;
    logic [31:0]        mv;
    logic [63:0]        wide;
    logic               extra;
    logic signed [11:0] s;
    logic [5:0]         sh;
    logic [30:0]        base;
    logic               inc;
    res   = 32'd0;
    field = 8'd0;
    mv    = n.mant;
    extra = 1'b0;
    s     = 12'sd1 - n.bexp;
    sh    = 6'd0;
    wide  = 64'd0;
    if (n.is_nan) begin
      res = F32_QNAN;
    end else if (n.is_inf || n.bexp >= 12'sd255) begin
      res = {n.sign, 31'h7F80_0000};
    end else if (n.is_zero) begin
      res = {n.sign, 31'd0};
    end else begin
      if (n.bexp >= 12'sd1) begin
        field = n.bexp[7:0];
      end else begin
        sh    = (s > 12'sd32) ? 6'd32 : s[5:0];
        wide  = {n.mant, 32'd0} >> sh;
        mv    = wide[63:32];
        extra = |wide[31:0];
      end
      base = {field, mv[30:8]};
      inc  = mv[7] & ((|mv[6:0]) | extra | mv[8]);
      res  = {n.sign, base + {30'd0, inc}};
    end
    return res;
  endfunction

  function automatic logic [15:0] to_bf16(input logic [31:0] f);
    logic [31:0] t;
    t = f + 32'h0000_7FFF + {31'd0, f[16]};
    if (f[30:23] == 8'hFF && f[22:0] != 23'd0) begin
      return BF16_QNAN;
    end
    return t[31:16];
  endfunction

endpackage

// ===== src/rope_fmul.sv =====
// ----------------------------------------------------------------------------
// rope_fmul: bf16 by fp32 multiplier, fp32 result
// Three stages: unpack and multiply, normalize, round to nearest even.
// ----------------------------------------------------------------------------
module rope_fmul (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [15:0] a,
  input  logic [31:0] b,
  output logic        out_valid,
  output logic [31:0] prod
);
  import rope_pkg::*;

  logic   v1, v2;
  fnorm_t r1, r2;

  logic       nan_a, inf_a, zero_a, nan_b, inf_b, zero_b;
  logic [7:0] ea_eff, eb_eff;
  fnorm_t     r1_next;

  always_comb begin
    nan_a  = (a[14:7] == 8'hFF) && (a[6:0] != 7'd0);
    inf_a  = (a[14:7] == 8'hFF) && (a[6:0] == 7'd0);
    zero_a = (a[14:7] == 8'h00) && (a[6:0] == 7'd0);
    nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    zero_b = (b[30:23] == 8'h00) && (b[22:0] == 23'd0);
    ea_eff = (a[14:7] == 8'h00) ? 8'd1 : a[14:7];
    eb_eff = (b[30:23] == 8'h00) ? 8'd1 : b[30:23];
    r1_next.sign    = a[15] ^ b[31];
    r1_next.is_nan  = nan_a | nan_b | (inf_a & zero_b) | (zero_a & inf_b);
    r1_next.is_inf  = inf_a | inf_b;
    r1_next.is_zero = zero_a | zero_b;
    r1_next.bexp    = $signed({4'b0, ea_eff}) + $signed({4'b0, eb_eff}) - 12'sd284;
    r1_next.mant    = {24'd0, (a[14:7] != 8'h00), a[6:0]}
                    * {8'd0, (b[30:23] != 8'h00), b[22:0]};
  end

  always_ff @(posedge clk) begin
    r1   <= r1_next;
    r2   <= norm32(r1);
    prod <= round32(r2);
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

// ===== src/rope_fadd.sv =====
// ----------------------------------------------------------------------------
// rope_fadd: fp32 adder
// Four stages: align, add, normalize, round to nearest even.
// ----------------------------------------------------------------------------
module rope_fadd (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_valid,
  output logic [31:0] sum
);
  import rope_pkg::*;

  typedef struct packed {
    logic       sbig;
    logic       ssmall;
    logic       is_nan;
    logic       is_inf;
    logic       inf_sign;
    logic [7:0] ebig;
    logic [26:0] mbig;
    logic [26:0] msmall;
  } align_t;

  logic   v1, v2, v3;
  align_t s1, s1_next;
  fnorm_t s2, s2_next, s3;

  logic        nan_a, inf_a, nan_b, inf_b, swap;
  logic [31:0] big, lesser;
  logic [7:0]  ebig_eff, esmall_eff, d;
  logic [26:0] msm;
  logic [53:0] wide;
  logic [27:0] ssum;

  always_comb begin
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    swap   = b[30:0] > a[30:0];
    big    = swap ? b : a;
    lesser = swap ? a : b;
    ebig_eff   = (big[30:23] == 8'h00) ? 8'd1 : big[30:23];
    esmall_eff = (lesser[30:23] == 8'h00) ? 8'd1 : lesser[30:23];
    d    = ebig_eff - esmall_eff;
    msm  = {(lesser[30:23] != 8'h00), lesser[22:0], 3'b000};
    wide = {msm, 27'd0} >> ((d > 8'd27) ? 8'd27 : d);
    s1_next.sbig     = big[31];
    s1_next.ssmall   = lesser[31];
    s1_next.is_nan   = nan_a | nan_b | (inf_a & inf_b & (a[31] != b[31]));
    s1_next.is_inf   = inf_a | inf_b;
    s1_next.inf_sign = inf_a ? a[31] : b[31];
    s1_next.ebig     = ebig_eff;
    s1_next.mbig     = {(big[30:23] != 8'h00), big[22:0], 3'b000};
    s1_next.msmall   = {wide[53:28], wide[27] | (|wide[26:0])};
  end

  always_comb begin
    if (s1.sbig ^ s1.ssmall) begin
      ssum = {1'b0, s1.mbig} - {1'b0, s1.msmall};
    end else begin
      ssum = {1'b0, s1.mbig} + {1'b0, s1.msmall};
    end
    s2_next.is_nan  = s1.is_nan;
    s2_next.is_inf  = s1.is_inf;
    s2_next.is_zero = (ssum == 28'd0);
    if (s1.is_inf) begin
      s2_next.sign = s1.inf_sign;
    end else if (ssum == 28'd0) begin
      s2_next.sign = s1.sbig & s1.ssmall;
    end else begin
      s2_next.sign = s1.sbig;
    end
    s2_next.bexp = $signed({4'b0, s1.ebig}) - 12'sd157;
    s2_next.mant = {ssum, 4'b0000};
  end

  always_ff @(posedge clk) begin
    s1  <= s1_next;
    s2  <= s2_next;
    s3  <= norm32(s2);
    sum <= round32(s3);
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

endmodule

// ===== src/rotary_embedding_qkv_split_core.sv =====
// ----------------------------------------------------------------------------
// rotary_embedding_qkv_split_core: rotate-half RoPE on fused QKV element pairs
// Rotates one element pair per beat and routes it to query, key or value.
// ----------------------------------------------------------------------------
// Usage:
//   An input beat is taken at a rising edge where start is high and busy is
//   low. It carries the row, head slot and pair index, the two bf16 elements
//   and the fp32 cosine and sine for both positions. Busy is high only while
//   rst is asserted, so a new beat may be offered in every cycle.
//   Each beat produces exactly one result beat. The result is shown for one
//   cycle with done high; the receiver has no way to hold it off, so it must
//   capture the beat in that cycle.
//   From the accepting edge to the done cycle a beat passes one input
//   register, three multiplier stages, four adder stages and one bf16
//   rounding and output stage. Throughput is one beat per cycle; the fp32
//   multiply and add pipelines set the depth.
//   Query and key heads get y_low = x_low*cos_low - x_high*sin_low and
//   y_high = x_high*cos_high + x_low*sin_high, every step rounded to nearest
//   even. The value head (any slot above the key slot) passes through.
//   The cache_prefix register is written with cfg_we and cfg_wdata; the user
//   writes only when idle (unchecked). Reset zeroes it, drops beats in flight.
// ----------------------------------------------------------------------------
module rotary_embedding_qkv_split_core #(
  parameter int HEAD_DIM        = rope_pkg::DEF_HEAD_DIM,
  parameter int NUM_QUERY_HEADS = rope_pkg::DEF_NUM_QUERY_HEADS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_we,
  input  logic [rope_pkg::PREFIX_W-1:0] cfg_wdata,
  input  logic [15:0]                  row_index,
  input  logic [3:0]                   head_index,
  input  logic [6:0]                   pair_index,
  input  logic [15:0]                  x_low,
  input  logic [15:0]                  x_high,
  input  logic [31:0]                  cos_low,
  input  logic [31:0]                  cos_high,
  input  logic [31:0]                  sin_low,
  input  logic [31:0]                  sin_high,
  output logic                         done,
  output logic [1:0]                   dest_kind,
  output logic [rope_pkg::INDEX_W-1:0] dest_index,
  output logic [15:0]                  y_low,
  output logic [15:0]                  y_high
);
  import rope_pkg::*;

  localparam int HALF       = HEAD_DIM / 2;
  localparam int ROW_STRIDE = NUM_QUERY_HEADS * HEAD_DIM;
  localparam int SIDE_DLY   = MUL_LAT + ADD_LAT;

  // Routing information that rides alongside the arithmetic.
  typedef struct packed {
    kind_t              kind;
    logic [INDEX_W-1:0] idx;
    logic [15:0]        xl;
    logic [15:0]        xh;
  } side_t;

  logic [PREFIX_W-1:0] cache_prefix;

  // Pair index reduced modulo half the head, as a constant table.
  logic [6:0] pair_mod_tab [128];
  for (genvar g = 0; g < 128; g++) begin : g_pair_tab
    localparam logic [6:0] PairMod = 7'(g % HALF);
    assign pair_mod_tab[g] = PairMod;
  end

  logic               in_valid;
  logic [6:0]         pair_mod;
  kind_t              kind_in;
  logic [INDEX_W-1:0] idx_in;

  assign busy     = rst;
  assign in_valid = start & ~busy;
  assign pair_mod = pair_mod_tab[pair_index];

  always_comb begin
    if ({3'b000, head_index} < 7'(NUM_QUERY_HEADS)) begin
      kind_in = KIND_QUERY;
      idx_in  = INDEX_W'(row_index) * INDEX_W'(ROW_STRIDE)
              + INDEX_W'(head_index) * INDEX_W'(HEAD_DIM)
              + INDEX_W'(pair_mod);
    end else begin
      kind_in = ({3'b000, head_index} == 7'(NUM_QUERY_HEADS)) ? KIND_KEY : KIND_VALUE;
      idx_in  = (INDEX_W'(cache_prefix) + INDEX_W'(row_index)) * INDEX_W'(HEAD_DIM)
              + INDEX_W'(pair_mod);
    end
  end

  // Input register stage.
  logic        s0_valid;
  side_t       s0_side;
  logic [31:0] s0_cl, s0_ch, s0_sl, s0_sh;

  always_ff @(posedge clk) begin
    s0_side.kind <= kind_in;
    s0_side.idx  <= idx_in;
    s0_side.xl   <= x_low;
    s0_side.xh   <= x_high;
    s0_cl        <= cos_low;
    s0_ch        <= cos_high;
    s0_sl        <= sin_low;
    s0_sh        <= sin_high;
    if (rst) begin
      s0_valid     <= 1'b0;
      cache_prefix <= '0;
    end else begin
      s0_valid <= in_valid;
      if (cfg_we) begin
        cache_prefix <= cfg_wdata;
      end
    end
  end

  // Four products, then one subtract and one add.
  logic        vm_lc, vm_ls, vm_hc, vm_hs;
  logic [31:0] p_lc, p_ls, p_hc, p_hs;
  logic        va_lo, va_hi;
  logic [31:0] r_lo, r_hi;

  rope_fmul u_mul_lc (.clk, .rst, .in_valid(s0_valid), .a(s0_side.xl), .b(s0_cl),
                      .out_valid(vm_lc), .prod(p_lc));
  rope_fmul u_mul_ls (.clk, .rst, .in_valid(s0_valid), .a(s0_side.xh), .b(s0_sl),
                      .out_valid(vm_ls), .prod(p_ls));
  rope_fmul u_mul_hc (.clk, .rst, .in_valid(s0_valid), .a(s0_side.xh), .b(s0_ch),
                      .out_valid(vm_hc), .prod(p_hc));
  rope_fmul u_mul_hs (.clk, .rst, .in_valid(s0_valid), .a(s0_side.xl), .b(s0_sh),
                      .out_valid(vm_hs), .prod(p_hs));

  // The low lane subtracts: flip the sign of the subtrahend.
  rope_fadd u_add_lo (.clk, .rst, .in_valid(vm_lc & vm_ls), .a(p_lc),
                      .b({~p_ls[31], p_ls[30:0]}), .out_valid(va_lo), .sum(r_lo));
  rope_fadd u_add_hi (.clk, .rst, .in_valid(vm_hc & vm_hs), .a(p_hc), .b(p_hs),
                      .out_valid(va_hi), .sum(r_hi));

  // Routing delay line matched to the arithmetic latency.
  side_t side_pipe [SIDE_DLY];

  always_ff @(posedge clk) begin
    side_pipe[0] <= s0_side;
    for (int i = 1; i < SIDE_DLY; i++) begin
      side_pipe[i] <= side_pipe[i-1];
    end
  end

  // Output stage: bf16 rounding, or pass-through for the value head.
  always_ff @(posedge clk) begin
    dest_kind  <= side_pipe[SIDE_DLY-1].kind;
    dest_index <= side_pipe[SIDE_DLY-1].idx;
    if (side_pipe[SIDE_DLY-1].kind == KIND_VALUE) begin
      y_low  <= side_pipe[SIDE_DLY-1].xl;
      y_high <= side_pipe[SIDE_DLY-1].xh;
    end else begin
      y_low  <= to_bf16(r_lo);
      y_high <= to_bf16(r_hi);
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= va_lo & va_hi;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rotary_embedding_qkv_split_core
// Drives element-pair beats through the start/busy command port, predicts
// each rotated or passed-through pair with a bit-accurate fp32 model built on
// double-precision arithmetic, and checks every done beat in order. The cache
// prefix register is swept through its extremes between traffic phases.
// ----------------------------------------------------------------------------
module testbench;
  import rope_pkg::*;

  localparam int HEAD_SIZE   = 256;
  localparam int HALF_SIZE   = HEAD_SIZE / 2;
  localparam int QUERY_HEADS = 8;
  localparam int DRAIN_CYCLES = 14;   // extra margin after the last result beat
  localparam int CYCLE_LIMIT  = 200000;

  // One element-pair beat as seen on the input ports.
  typedef struct {
    logic [15:0] row;
    logic [3:0]  head;
    logic [6:0]  pair;
    logic [15:0] xl;
    logic [15:0] xh;
    logic [31:0] cl;
    logic [31:0] ch;
    logic [31:0] sl;
    logic [31:0] sh;
  } pair_beat_t;

  // One expected result beat.
  typedef struct {
    kind_t        kind;
    logic [28:0]  index;
    logic [15:0]  yl;
    logic [15:0]  yh;
  } rotated_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic cfg_we = 1'b0;
  logic [PREFIX_W-1:0] cfg_wdata = '0;
  logic [15:0] row_index = '0;
  logic [3:0]  head_index = '0;
  logic [6:0]  pair_index = '0;
  logic [15:0] x_low = '0;
  logic [15:0] x_high = '0;
  logic [31:0] cos_low = '0;
  logic [31:0] cos_high = '0;
  logic [31:0] sin_low = '0;
  logic [31:0] sin_high = '0;
  logic busy;
  logic done;
  logic [1:0] dest_kind;
  logic [INDEX_W-1:0] dest_index;
  logic [15:0] y_low;
  logic [15:0] y_high;

  // The bench's own copy of the cache prefix register.
  logic [PREFIX_W-1:0] prefix_shadow = '0;
  // Rotated pairs that have been accepted but not yet seen on the outputs.
  rotated_pair_t pending_pairs[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  // Percentage of beats preceded by an idle stretch on the sender side.
  int idle_pct = 0;

  always #2 clk = ~clk;

  rotary_embedding_qkv_split_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .row_index(row_index), .head_index(head_index), .pair_index(pair_index),
    .x_low(x_low), .x_high(x_high),
    .cos_low(cos_low), .cos_high(cos_high), .sin_low(sin_low), .sin_high(sin_high),
    .done(done), .dest_kind(dest_kind), .dest_index(dest_index),
    .y_low(y_low), .y_high(y_high)
  );

  // --------------------------------------------------------------------------
  // Float helpers. An fp32 product is exact in double precision, and a sum of
  // two fp32 values computed in double and then rounded once to fp32 matches
  // a direct fp32 add, so double arithmetic plus a careful final rounding
  // reproduces round-to-nearest-even fp32 behavior including subnormals.
  // --------------------------------------------------------------------------
  function automatic logic [63:0] widen_f32(input logic [31:0] f);
    logic [23:0] m;
    int ex;
    m  = {1'b0, f[22:0]};
    ex = -126;
    if (f[30:23] == 8'hFF) begin
      return {f[31], 11'h7FF, (f[22:0] != 0), 51'd0};
    end
    if (f[30:23] == 8'h00) begin
      if (m == 0) begin
        return {f[31], 63'd0};
      end
      // Subnormal input: normalize so that the hidden bit is explicit.
      while (!m[23]) begin
        m  = m << 1;
        ex = ex - 1;
      end
      return {f[31], 11'(ex + 1023), m[22:0], 29'd0};
    end
    return {f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0};
  endfunction

  function automatic logic [31:0] narrow_f64(input logic [63:0] d);
    int e, shift;
    logic [63:0] m, kept, lost, halfv;
    logic [7:0]  fld;
    logic [30:0] base;
    logic        inc;
    e = int'(d[62:52]) - 1023;
    if (d[62:52] == 11'h7FF) begin
      return (d[51:0] != 0) ? F32_QNAN : {d[63], 31'h7F80_0000};
    end
    // A double subnormal is far below half the smallest fp32 subnormal.
    if (d[62:52] == 11'h000) begin
      return {d[63], 31'd0};
    end
    if (e > 127) begin
      return {d[63], 31'h7F80_0000};
    end
    m = {11'd0, 1'b1, d[51:0]};
    if (e >= -126) begin
      shift = 29;
      fld   = 8'(e + 127);
    end else begin
      shift = 29 + (-126 - e);
      fld   = 8'd0;
    end
    if (shift > 60) begin
      shift = 60;
    end
    kept  = m >> shift;
    lost  = m & ((64'd1 << shift) - 64'd1);
    halfv = 64'd1 << (shift - 1);
    inc   = (lost > halfv) || (lost == halfv && kept[0]);
    // A carry out of the mantissa bumps the exponent, up to infinity.
    base  = {fld, kept[22:0]} + {30'd0, inc};
    return {d[63], base};
  endfunction

  function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
    return narrow_f64($realtobits($bitstoreal(widen_f32(a)) * $bitstoreal(widen_f32(b))));
  endfunction

  function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
    return narrow_f64($realtobits($bitstoreal(widen_f32(a)) + $bitstoreal(widen_f32(b))));
  endfunction

  function automatic logic [15:0] round_to_bf16(input logic [31:0] f);
    logic [31:0] t;
    t = f + 32'h0000_7FFF + {31'd0, f[16]};
    if (f[30:23] == 8'hFF && f[22:0] != 0) begin
      return BF16_QNAN;
    end
    return t[31:16];
  endfunction

  // Works out the result beat for one accepted pair under the current prefix.
  function automatic rotated_pair_t rotate_pair(input pair_beat_t p);
    rotated_pair_t r;
    logic [31:0] fxl, fxh;
    logic [63:0] idx;
    fxl = {p.xl, 16'd0};
    fxh = {p.xh, 16'd0};
    if (p.head < QUERY_HEADS) begin
      r.kind = KIND_QUERY;
      idx = 64'(p.row) * QUERY_HEADS * HEAD_SIZE + 64'(p.head) * HEAD_SIZE
          + 64'(p.pair % HALF_SIZE);
    end else begin
      // Every slot past the key slot is treated as the value head.
      r.kind = (p.head == QUERY_HEADS) ? KIND_KEY : KIND_VALUE;
      idx = (64'(prefix_shadow) + 64'(p.row)) * HEAD_SIZE + 64'(p.pair % HALF_SIZE);
    end
    r.index = idx[28:0];
    if (r.kind == KIND_VALUE) begin
      r.yl = p.xl;
      r.yh = p.xh;
    end else begin
      // Subtract is an add with the sine product's sign flipped.
      r.yl = round_to_bf16(fp32_add(fp32_mul(fxl, p.cl),
                                    fp32_mul(fxh, p.sl) ^ 32'h8000_0000));
      r.yh = round_to_bf16(fp32_add(fp32_mul(fxh, p.ch), fp32_mul(fxl, p.sh)));
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Expectations are queued at the accepting edge and retired on done. Both
  // sides of the comparison are register outputs sampled at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rotated_pair_t want;
    pair_beat_t p;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
    if (!rst && start && !busy) begin
      p = '{row_index, head_index, pair_index, x_low, x_high,
            cos_low, cos_high, sin_low, sin_high};
      pending_pairs.push_back(rotate_pair(p));
    end
    if (!rst && done) begin
      if (pending_pairs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result beat: kind %0d index %h y %h %h",
                   dest_kind, dest_index, y_low, y_high);
        end
      end else begin
        want = pending_pairs.pop_front();
        if (dest_kind != want.kind || dest_index != want.index ||
            y_low != want.yl || y_high != want.yh) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: kind %0d/%0d index %h/%h y_low %h/%h y_high %h/%h",
                     dest_kind, want.kind, dest_index, want.index,
                     y_low, want.yl, y_high, want.yh);
          end
        end
      end
    end
  end

  // Offers one beat and returns after the edge that accepts it. Start is only
  // lowered when an idle stretch comes first, so it never toggles twice.
  task automatic send_pair(input pair_beat_t p);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    row_index  <= p.row;
    head_index <= p.head;
    pair_index <= p.pair;
    x_low      <= p.xl;
    x_high     <= p.xh;
    cos_low    <= p.cl;
    cos_high   <= p.ch;
    sin_low    <= p.sl;
    sin_high   <= p.sh;
    // Busy only changes on rising edges, so the falling edge sees it stable.
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  // Stops offering beats and waits until every result beat is back.
  task automatic drain_pairs();
    start <= 1'b0;
    @(posedge clk);
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the cache prefix; only called with the block drained.
  task automatic write_prefix(input logic [PREFIX_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    prefix_shadow = value;
    @(posedge clk);
  endtask

  // A value in the range of realistic activations or trig values, so that
  // most rotations exercise ordinary rounding rather than specials.
  function automatic logic [31:0] plausible_f32(input int lo_exp, input int hi_exp);
    return {1'($urandom), 8'($urandom_range(hi_exp, lo_exp)), 23'($urandom)};
  endfunction

  function automatic pair_beat_t random_pair();
    pair_beat_t p;
    logic [31:0] t;
    p.row  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(31));
    p.head = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
    p.pair = 7'($urandom);
    if ($urandom_range(4) == 0) begin
      // Raw bit patterns: reaches NaNs, infinities and subnormals.
      p.xl = 16'($urandom); p.xh = 16'($urandom);
      p.cl = $urandom; p.ch = $urandom; p.sl = $urandom; p.sh = $urandom;
    end else begin
      t = plausible_f32(110, 130); p.xl = t[31:16];
      t = plausible_f32(110, 130); p.xh = t[31:16];
      p.cl = plausible_f32(100, 126); p.ch = plausible_f32(100, 126);
      p.sl = plausible_f32(100, 126); p.sh = plausible_f32(100, 126);
    end
    return p;
  endfunction

  // Extremes of every field, every head slot and the special float values.
  task automatic test_directed_edges();
    pair_beat_t p;
    idle_pct = 0;
    for (int h = 0; h < 16; h++) begin
      p = '{16'(h * 4099), 4'(h), 7'(h * 9), 16'h3F80, 16'hC040,
            32'h3F35_04F3, 32'hBF00_0000, 32'h3F35_04F3, 32'h3E80_0000};
      send_pair(p);
    end
    // Largest row and pair, all-ones data.
    send_pair('{16'hFFFF, 4'd7, 7'd127, 16'hFFFF, 16'hFFFF, '1, '1, '1, '1});
    send_pair('{16'hFFFF, 4'd8, 7'd127, 16'h7F7F, 16'h7F7F,
                32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF});
    // Infinity times zero gives NaN; signed zeros cancel.
    send_pair('{16'd0, 4'd0, 7'd0, 16'h7F80, 16'h8000,
                32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'h0000_0000});
    // Subnormal operands and products that underflow toward zero.
    send_pair('{16'd1, 4'd3, 7'd1, 16'h0001, 16'h0080,
                32'h0000_0001, 32'h007F_FFFF, 32'h3F80_0000, 32'h0080_0000});
    send_pair('{16'd2, 4'd8, 7'd64, 16'h0040, 16'h8040,
                32'h3F00_0001, 32'h3F7F_FFFF, 32'h3F00_0000, 32'hBF7F_FFFF});
    // Value head carrying NaN and infinity bit patterns through untouched.
    send_pair('{16'd3, 4'd9, 7'd5, 16'h7FC1, 16'hFF80, '1, '0, '1, '0});
    // NaN cosine on a key slot.
    send_pair('{16'd4, 4'd8, 7'd6, 16'h3F80, 16'h3F80,
                32'h7FA0_0000, 32'h3F80_0000, 32'h0000_0000, 32'h7F80_0001});
    drain_pairs();
  endtask

  // Prefix extremes, including the largest prefix with the largest row.
  task automatic test_prefix_sweep();
    logic [PREFIX_W-1:0] prefixes[4];
    prefixes = '{20'hFFFFF, 20'h00001, 20'h5A5A5, 20'h00000};
    idle_pct = 30;
    foreach (prefixes[k]) begin
      write_prefix(prefixes[k]);
      repeat (8) send_pair(random_pair());
      send_pair('{16'hFFFF, 4'd9, 7'd127, 16'h1234, 16'hABCD, '0, '0, '0, '0});
      send_pair('{16'hFFFF, 4'd8, 7'd127, 16'h3F80, 16'h3F80, '1, '0, '0, '1});
      drain_pairs();
    end
  endtask

  // Long random stream over the idling phases. Each phase writes a new prefix
  // and ends by waiting for every result in flight.
  task automatic test_random_stream();
    int pcts[4];
    pcts = '{0, 60, 20, 0};
    foreach (pcts[ph]) begin
      idle_pct = pcts[ph];
      write_prefix(20'($urandom));
      repeat (115) send_pair(random_pair());
      drain_pairs();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_prefix_sweep();
    test_random_stream();
    if (mismatch_count == 0 && pending_pairs.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
